// File: sv/pip_pkg.sv
// pip_pkg: shared types and constants for the point-in-polygon test block
// used by pip_ctrl, pip_datapath and point_in_polygon_test; no dependencies
package pip_pkg;

    // default sizes handed to the top level parameters
    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 32;

    // output tdata holds the single result bit, padded to a byte
    localparam int OUT_TDATA_W = 8;

    // opcode carried in the input tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TEST  = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic wr_en;    // store the incoming vertex
        logic load_pt;  // capture the test point and clear parity
        logic rd_en;    // read one edge (two vertices)
        logic rd_last;  // this read is the final edge of the walk
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic done;     // last edge has been folded into parity
        logic parity;   // running crossing parity
    } t_dp_stat;

endpackage

// File: sv/pip_datapath.sv
// pip_datapath: vertex memory and the pipelined edge-crossing evaluator
// depends on pip_pkg (t_dp_cmd, t_dp_stat)
module pip_datapath import pip_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int IDX_W        = $clog2(MAX_VERTICES)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    input  logic [IDX_W-1:0]             i_wr_index,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic [IDX_W-1:0]             i_rd_addr_i,
    input  logic [IDX_W-1:0]             i_rd_addr_j,
    output t_dp_stat                     o_stat
);

    localparam int CB   = COORD_BITS;
    localparam int CB1  = COORD_BITS + 1;        // width of a coordinate difference
    localparam int H    = (CB1 + 1) / 2;          // low slice of the split multiplier
    localparam int HW   = CB1 - H;                // high slice width
    localparam int PW   = 2 * CB1;                // exact product width
    localparam int SLOT_W = $clog2(MAX_VERTICES + 1);

    // vertex memory, one word holds {y, x}
    logic [2*CB-1:0] r_mem [MAX_VERTICES];

    logic                  wr_ok;
    assign wr_ok = SLOT_W'(i_wr_index) < SLOT_W'(MAX_VERTICES);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && wr_ok) begin
            r_mem[i_wr_index] <= {i_coord_y, i_coord_x};
        end
    end

    // test point capture
    logic signed [CB-1:0] r_px, r_py;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pt) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
    end

    // stage 1: registered memory reads of both edge ends
    logic            r_v1, r_l1;
    logic [2*CB-1:0] r_rd_i, r_rd_j;
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_i <= r_mem[i_rd_addr_i];
            r_rd_j <= r_mem[i_rd_addr_j];
        end
    end

    logic signed [CB-1:0] xi, yi, xj, yj;
    assign xi = $signed(r_rd_i[CB-1:0]);
    assign yi = $signed(r_rd_i[2*CB-1:CB]);
    assign xj = $signed(r_rd_j[CB-1:0]);
    assign yj = $signed(r_rd_j[2*CB-1:CB]);

    // stage 2: differences and straddle check
    logic                  r_v2, r_l2, r_str2;
    logic signed [CB1-1:0] r_dxp, r_dy, r_dxe, r_dyp;
    always_ff @(posedge i_clk) begin
        r_dxp  <= CB1'(r_px) - CB1'(xi);
        r_dy   <= CB1'(yj) - CB1'(yi);
        r_dxe  <= CB1'(xj) - CB1'(xi);
        r_dyp  <= CB1'(r_py) - CB1'(yi);
        r_str2 <= (yi > r_py) != (yj > r_py);
    end

    // stage 3: split partial products of both cross terms
    logic                     r_v3, r_l3, r_str3, r_neg3;
    logic signed [CB1+H:0]    r_llo, r_rlo;
    logic signed [CB1+HW-1:0] r_lhi, r_rhi;
    always_ff @(posedge i_clk) begin
        r_llo  <= r_dxp * $signed({1'b0, r_dy[H-1:0]});
        r_lhi  <= r_dxp * $signed(r_dy[CB1-1:H]);
        r_rlo  <= r_dxe * $signed({1'b0, r_dyp[H-1:0]});
        r_rhi  <= r_dxe * $signed(r_dyp[CB1-1:H]);
        r_str3 <= r_str2;
        r_neg3 <= r_dy[CB1-1];
    end

    // stage 4: recombine partial products into exact cross terms
    logic                 r_v4, r_l4, r_str4, r_neg4;
    logic signed [PW-1:0] r_lhs, r_rhs;
    always_ff @(posedge i_clk) begin
        r_lhs  <= (PW'(r_lhi) <<< H) + PW'(r_llo);
        r_rhs  <= (PW'(r_rhi) <<< H) + PW'(r_rlo);
        r_str4 <= r_str3;
        r_neg4 <= r_neg3;
    end

    // crossing decision, sign of the y difference picks the compare direction
    logic crosses;
    assign crosses = r_neg4 ? (r_rhs < r_lhs) : (r_lhs < r_rhs);

    // pipeline control bits and parity accumulation
    logic r_parity, r_done;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_l1 <= 1'b0;
            r_v2 <= 1'b0; r_l2 <= 1'b0;
            r_v3 <= 1'b0; r_l3 <= 1'b0;
            r_v4 <= 1'b0; r_l4 <= 1'b0;
            r_parity <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_l1 <= i_cmd.rd_last;
            r_v2 <= r_v1; r_l2 <= r_l1 && r_v1;
            r_v3 <= r_v2; r_l3 <= r_l2 && r_v2;
            r_v4 <= r_v3; r_l4 <= r_l3 && r_v3;
            r_done <= r_v4 && r_l4;
            if (i_cmd.load_pt) begin
                r_parity <= 1'b0;
            end else if (r_v4 && r_str4 && crosses) begin
                r_parity <= ~r_parity;
            end
        end
    end

    assign o_stat.done   = r_done;
    assign o_stat.parity = r_parity;

    // at most one end-of-walk marker in flight
    a_one_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_l1 && r_v1, r_l2 && r_v2, r_l3 && r_v3, r_l4 && r_v4}) <= 1)
        else $error("more than one last edge in the pipeline");

    // a new point never arrives while edges are still being evaluated
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_pt |-> !(r_v1 || r_v2 || r_v3 || r_v4))
        else $error("test point loaded during an edge walk");

    // done follows the last edge leaving stage 4
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_l4) |=> r_done)
        else $error("done missing after last edge");

endmodule

// File: sv/pip_ctrl.sv
// pip_ctrl: handshake, vertex count register and edge walk sequencer
// depends on pip_pkg (t_dp_cmd, t_dp_stat, opcodes)
module pip_ctrl import pip_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int IDX_W        = $clog2(MAX_VERTICES),
    parameter int CNT_W        = $clog2(MAX_VERTICES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_opcode,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    output logic             o_m_inside,
    input  logic             i_m_tready,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    output t_dp_cmd          o_cmd,
    output logic [IDX_W-1:0] o_rd_addr_i,
    output logic [IDX_W-1:0] o_rd_addr_j,
    input  t_dp_stat         i_stat
);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN, S_FINISH} t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_count;
    logic             r_out_valid, r_out_inside;

    // vertex count saturated to the store depth
    logic [CNT_W-1:0] n_sat;
    assign n_sat = (r_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : r_count;

    logic s_acc, is_last, out_free;
    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign is_last    = CNT_W'(r_idx) == (n_sat - CNT_W'(1));
    assign out_free   = !r_out_valid || i_m_tready;

    // commands and read addresses, predecessor of vertex 0 is the last vertex
    always_comb begin
        o_cmd.wr_en   = s_acc && (i_s_opcode == OP_WRITE);
        o_cmd.load_pt = s_acc && (i_s_opcode == OP_TEST);
        o_cmd.rd_en   = (r_state == S_WALK);
        o_cmd.rd_last = (r_state == S_WALK) && is_last;
        o_rd_addr_i   = r_idx;
        o_rd_addr_j   = (r_idx == '0) ? IDX_W'(n_sat - CNT_W'(1)) : r_idx - IDX_W'(1);
    end

    // state, walk index, config register and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_out_inside <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            // finish reloads the output register itself
            if (r_out_valid && i_m_tready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (s_acc && (i_s_opcode == OP_TEST)) begin
                        r_state <= (n_sat == '0) ? S_FINISH : S_WALK;
                    end
                end
                S_WALK: begin
                    r_idx <= r_idx + IDX_W'(1);
                    if (is_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (i_stat.done) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_inside <= i_stat.parity;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_inside = r_out_inside;

    // end of walk reported only while draining
    a_done_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.done |-> (r_state == S_DRAIN))
        else $error("walk done outside drain");

    // walk index stays below the vertex count
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (CNT_W'(r_idx) < n_sat))
        else $error("edge index beyond vertex count");

    // a test with vertices starts a walk
    a_test_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_pt && (n_sat != '0)) |=> (r_state == S_WALK))
        else $error("test did not start an edge walk");

    // a held result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_out_valid && !i_m_tready) |=> r_out_valid)
        else $error("pending result dropped");

endmodule

// File: sv/point_in_polygon_test.sv
// point_in_polygon_test: top level, stream ports and field unpacking
// depends on pip_pkg, pip_ctrl and pip_datapath
//
// Usage:
//   Input stream (s_axis): tuser carries the opcode. A write transaction stores
//   one vertex (x, y) in slot vertex_index and gives no result. A test
//   transaction carries a point; the block walks all edges of the polygon and
//   returns one result transaction on m_axis with bit 0 = inside (odd crossing
//   count). Coordinates are signed fixed point, COORD_BITS wide.
//   Configuration: i_cfg_we writes the vertex count, to be used only while idle
//   (the block does not enforce this); counts above MAX_VERTICES act as MAX_VERTICES.
//   Timing: a test with n vertices walks one edge per cycle through a
//   four-stage pipeline whose first stage reads the two-port vertex memory;
//   the next transaction is accepted from the same cycle in which
//   o_m_axis_tvalid rises.
//   Reset clears the count to zero, the sequencer and the output valid; the
//   vertex memory is not cleared and must be written before it is tested.
//   When the receiver stalls, the result is held in the output register; the
//   block still accepts the next transaction and waits at the end of that test
//   until the held result is taken.
module point_in_polygon_test import pip_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF,
    localparam int IDX_W       = $clog2(MAX_VERTICES),
    localparam int CNT_W       = $clog2(MAX_VERTICES + 1),
    localparam int IN_TDATA_W  = ((IDX_W + 2 * COORD_BITS) + 7) / 8 * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // vertex_index, coord_x, coord_y, zero pad
    input  logic                   i_s_axis_tuser,  // opcode
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // inside_res, zero pad
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CNT_W-1:0]       i_cfg_wdata      // vertex_count
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic [IDX_W-1:0] rd_addr_i, rd_addr_j;
    logic             res_inside;

    // unpack input fields
    logic [IDX_W-1:0]             s_index;
    logic signed [COORD_BITS-1:0] s_x, s_y;
    assign s_index = i_s_axis_tdata[IDX_W-1:0];
    assign s_x     = $signed(i_s_axis_tdata[IDX_W+COORD_BITS-1:IDX_W]);
    assign s_y     = $signed(i_s_axis_tdata[IDX_W+2*COORD_BITS-1:IDX_W+COORD_BITS]);

    pip_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_axis_tvalid),
        .i_s_opcode  (i_s_axis_tuser),
        .o_s_tready  (o_s_axis_tready),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_m_inside  (res_inside),
        .i_m_tready  (i_m_axis_tready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cmd       (cmd),
        .o_rd_addr_i (rd_addr_i),
        .o_rd_addr_j (rd_addr_j),
        .i_stat      (stat)
    );

    pip_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS),
        .IDX_W        (IDX_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_wr_index  (s_index),
        .i_coord_x   (s_x),
        .i_coord_y   (s_y),
        .i_rd_addr_i (rd_addr_i),
        .i_rd_addr_j (rd_addr_j),
        .o_stat      (stat)
    );

    // pack result
    assign o_m_axis_tdata = {(OUT_TDATA_W - 1)'(0), res_inside};

endmodule
